/* hdl/edge_velocity_gradient_q_assert.svh */
// Assertion macros shared by the block
`ifndef EDGE_VELOCITY_GRADIENT_Q_ASSERT_SVH
`define EDGE_VELOCITY_GRADIENT_Q_ASSERT_SVH

// same-cycle implication
`define EVG_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("edge_velocity_gradient_q check failed");

// next-cycle implication
`define EVG_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("edge_velocity_gradient_q check failed");

// implication after a fixed number of cycles
`define EVG_ASSERT_AFTER(lbl, ante, dly, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> ##(dly) (cons)) \
      else $error("edge_velocity_gradient_q check failed");

`endif

/* hdl/evg_pkg.sv */
`timescale 1ns / 1ps
package evg_pkg;

   localparam int FRAC_BITS = 16;
   localparam int TOL_W     = 16;
   localparam int DIFF_W    = 33;
   localparam int QUOT_W    = 32;

   localparam int FRONT_LAT = 2;
   localparam int DIV_LAT   = 34;
   localparam int SQRT_LAT  = 34;
   localparam int PROD_LAT  = 5;
   localparam int TOTAL_LAT = FRONT_LAT + DIV_LAT + PROD_LAT;

   localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(1);

   typedef struct packed {
      logic [2:0][DIFF_W-1:0] dx_mag;
      logic [2:0][DIFF_W-1:0] dv_mag;
      logic [2:0]             dx_neg;
      logic [2:0]             dv_neg;
      logic                   ok;
   } front_type;

endpackage

/* hdl/evg_front.sv */
`timescale 1ns / 1ps
module evg_front (
   input  logic                          clock,
   input  logic [2:0][31:0]              start_pos,
   input  logic [2:0][31:0]              end_pos,
   input  logic [2:0][31:0]              start_vel,
   input  logic [2:0][31:0]              end_vel,
   input  logic [evg_pkg::TOL_W-1:0]     tolerance,
   output evg_pkg::front_type            front
);

   localparam int W = evg_pkg::DIFF_W;

   logic [2:0][W-1:0] dx_ff, dv_ff;
   evg_pkg::front_type front_ff, front_in;

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         dx_ff[i] <= W'($signed(end_pos[i])) - W'($signed(start_pos[i]));
         dv_ff[i] <= W'($signed(end_vel[i])) - W'($signed(start_vel[i]));
      end
   end

   always_comb begin
      front_in.ok = 1'b1;
      for (int i = 0; i < 3; i++) begin
         front_in.dx_neg[i] = dx_ff[i][W-1];
         front_in.dv_neg[i] = dv_ff[i][W-1];
         front_in.dx_mag[i] = dx_ff[i][W-1] ? (~dx_ff[i] + W'(1)) : dx_ff[i];
         front_in.dv_mag[i] = dv_ff[i][W-1] ? (~dv_ff[i] + W'(1)) : dv_ff[i];
         if (front_in.dx_mag[i] <= W'(tolerance))
            front_in.ok = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      front_ff <= front_in;
   end

   assign front = front_ff;

endmodule

/* hdl/evg_div.sv */
`timescale 1ns / 1ps
module evg_div #(
   parameter int FRAC_BITS = evg_pkg::FRAC_BITS
) (
   input  logic                         clock,
   input  logic [evg_pkg::DIFF_W-1:0]   num_mag,
   input  logic                         num_neg,
   input  logic [evg_pkg::DIFF_W-1:0]   den_mag,
   input  logic                         den_neg,
   output logic [evg_pkg::QUOT_W-1:0]   quot,
   output logic                         sat
);

   localparam int DW = evg_pkg::DIFF_W;
   localparam int QB = evg_pkg::QUOT_W;
   localparam int CW = DW + QB + 1;

   logic [CW-1:0] rem_ff [0:QB-1];
   logic [DW-1:0] den_ff [0:QB-1];
   logic [QB-1:0] q_ff   [0:QB];
   logic          neg_ff [0:QB];
   logic          ovf_ff [0:QB];
   logic [QB-1:0] quot_ff;
   logic          sat_ff;

   logic [CW-1:0] num_ext;
   assign num_ext = CW'({num_mag, {FRAC_BITS{1'b0}}});

   // quotient of 2^32 or more can only saturate
   always_ff @(posedge clock) begin
      rem_ff[0] <= num_ext;
      den_ff[0] <= den_mag;
      q_ff[0]   <= '0;
      neg_ff[0] <= num_neg ^ den_neg;
      ovf_ff[0] <= num_ext >= (CW'(den_mag) << QB);
   end

   for (genvar g = 1; g <= QB; g++) begin : g_bit
      localparam int K = QB - g;
      logic [CW-1:0] sub;
      logic          fit;
      logic [QB-1:0] q_in;

      assign sub = CW'(den_ff[g-1]) << K;
      assign fit = rem_ff[g-1] >= sub;

      always_comb begin
         q_in    = q_ff[g-1];
         q_in[K] = fit;
      end

      always_ff @(posedge clock) begin
         q_ff[g]   <= q_in;
         neg_ff[g] <= neg_ff[g-1];
         ovf_ff[g] <= ovf_ff[g-1];
      end

      if (g < QB) begin : g_rem
         always_ff @(posedge clock) begin
            rem_ff[g] <= fit ? (rem_ff[g-1] - sub) : rem_ff[g-1];
            den_ff[g] <= den_ff[g-1];
         end
      end
   end

   localparam logic [QB-1:0] POS_MAX = {1'b0, {(QB-1){1'b1}}};
   localparam logic [QB-1:0] NEG_MAX = {1'b1, {(QB-1){1'b0}}};

   always_ff @(posedge clock) begin
      if (neg_ff[QB]) begin
         if (ovf_ff[QB] || (q_ff[QB] > NEG_MAX)) begin
            quot_ff <= NEG_MAX;
            sat_ff  <= 1'b1;
         end else begin
            quot_ff <= ~q_ff[QB] + QB'(1);
            sat_ff  <= 1'b0;
         end
      end else begin
         if (ovf_ff[QB] || (q_ff[QB] > POS_MAX)) begin
            quot_ff <= POS_MAX;
            sat_ff  <= 1'b1;
         end else begin
            quot_ff <= q_ff[QB];
            sat_ff  <= 1'b0;
         end
      end
   end

   assign quot = quot_ff;
   assign sat  = sat_ff;

endmodule

/* hdl/evg_sqrt.sv */
`timescale 1ns / 1ps
module evg_sqrt (
   input  logic                          clock,
   input  logic [2:0][evg_pkg::DIFF_W-1:0] dx_mag,
   output logic [31:0]                   half_len
);

   localparam int DW = evg_pkg::DIFF_W;
   localparam int SW = 2 * DW;
   localparam int RB = 32;
   localparam int CW = SW;

   logic [SW-1:0] sq_ff [0:2];
   logic [CW-1:0] rem_ff  [0:RB-1];
   logic [RB-1:0] root_ff [0:RB];

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++)
         sq_ff[i] <= SW'(dx_mag[i]) * SW'(dx_mag[i]);
   end

   // quarter of the squared length; sum stays below 2^66
   logic [SW+1:0] sq_sum;
   assign sq_sum = (SW+2)'(sq_ff[0]) + (SW+2)'(sq_ff[1]) + (SW+2)'(sq_ff[2]);

   always_ff @(posedge clock) begin
      rem_ff[0]  <= sq_sum[SW+1:2];
      root_ff[0] <= '0;
   end

   for (genvar g = 1; g <= RB; g++) begin : g_bit
      localparam int K = RB - g;
      logic [CW-1:0] trial;
      logic          fit;
      logic [RB-1:0] root_in;

      assign trial = (CW'(root_ff[g-1]) << (K + 1)) + (CW'(1) << (2 * K));
      assign fit   = rem_ff[g-1] >= trial;

      always_comb begin
         root_in    = root_ff[g-1];
         root_in[K] = fit;
      end

      always_ff @(posedge clock) begin
         root_ff[g] <= root_in;
      end

      if (g < RB) begin : g_rem
         always_ff @(posedge clock) begin
            rem_ff[g] <= fit ? (rem_ff[g-1] - trial) : rem_ff[g-1];
         end
      end
   end

   assign half_len = root_ff[RB];

endmodule

/* hdl/evg_qsum.sv */
`timescale 1ns / 1ps
module evg_qsum #(
   parameter int FRAC_BITS = evg_pkg::FRAC_BITS
) (
   input  logic              clock,
   input  logic [8:0][31:0]  tensor,
   input  logic              sat_in,
   output logic [31:0]       q_val,
   output logic              sat_out
);

   localparam logic signed [63:0] BIAS = 64'((64'sd1 <<< FRAC_BITS) - 64'sd1);
   localparam logic signed [66:0] Q_MAX = 67'sd2147483647;
   localparam logic signed [66:0] Q_MIN = -67'sd2147483648;

   logic signed [63:0] prod_ff  [0:5];
   logic signed [63:0] scale_ff [0:5];
   logic signed [65:0] part_ff  [0:2];
   logic signed [66:0] total_ff;
   logic [3:0]         sat_ff;
   logic [31:0]        q_ff;
   logic               qsat_ff;

   // element index is row * 3 + column
   always_ff @(posedge clock) begin
      prod_ff[0] <= $signed(tensor[0]) * $signed(tensor[4]);
      prod_ff[1] <= $signed(tensor[4]) * $signed(tensor[8]);
      prod_ff[2] <= $signed(tensor[8]) * $signed(tensor[0]);
      prod_ff[3] <= $signed(tensor[1]) * $signed(tensor[3]);
      prod_ff[4] <= $signed(tensor[5]) * $signed(tensor[7]);
      prod_ff[5] <= $signed(tensor[2]) * $signed(tensor[6]);
      sat_ff[0]  <= sat_in;
   end

   // scale down, truncating toward zero
   always_ff @(posedge clock) begin
      for (int i = 0; i < 6; i++)
         scale_ff[i] <= (prod_ff[i] + (prod_ff[i][63] ? BIAS : 64'sd0)) >>> FRAC_BITS;
      sat_ff[1] <= sat_ff[0];
   end

   always_ff @(posedge clock) begin
      part_ff[0] <= 66'(scale_ff[0]) + 66'(scale_ff[1]);
      part_ff[1] <= 66'(scale_ff[2]) - 66'(scale_ff[3]);
      part_ff[2] <= -66'(scale_ff[4]) - 66'(scale_ff[5]);
      sat_ff[2]  <= sat_ff[1];
   end

   always_ff @(posedge clock) begin
      total_ff  <= 67'(part_ff[0]) + 67'(part_ff[1]) + 67'(part_ff[2]);
      sat_ff[3] <= sat_ff[2];
   end

   always_ff @(posedge clock) begin
      if (total_ff > Q_MAX) begin
         q_ff    <= Q_MAX[31:0];
         qsat_ff <= 1'b1;
      end else if (total_ff < Q_MIN) begin
         q_ff    <= Q_MIN[31:0];
         qsat_ff <= 1'b1;
      end else begin
         q_ff    <= total_ff[31:0];
         qsat_ff <= sat_ff[3];
      end
   end

   assign q_val   = q_ff;
   assign sat_out = qsat_ff;

endmodule

/* hdl/edge_velocity_gradient_q.sv */
`timescale 1ns / 1ps
// channel   | handshake           | beat
// ----------+---------------------+-------------------------------------------
// request   | start, busy         | req_start_*, req_end_*, req_*_vel_*
// response  | rsp_valid (strobe)  | rsp_edge_valid, rsp_q_invariant,
//           |                     | rsp_half_length, rsp_saturated
// csr       | csr_we              | csr_wdata (tolerance)
//
// One beat per cycle. A request goes through the front end, the one-bit-per-stage
// tensor dividers (34 stages) and then the product and sum pipeline
// (5 stages) before it shows on rsp_valid. busy is always low: the pipeline
// never stalls, and the receiver must take every strobe. Synchronous reset
// clears the valid line and sets the tolerance to one LSB.
module edge_velocity_gradient_q #(
   parameter int FRAC_BITS = evg_pkg::FRAC_BITS
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic signed [31:0]        req_start_x,
   input  logic signed [31:0]        req_start_y,
   input  logic signed [31:0]        req_start_z,
   input  logic signed [31:0]        req_end_x,
   input  logic signed [31:0]        req_end_y,
   input  logic signed [31:0]        req_end_z,
   input  logic signed [31:0]        req_start_vel_x,
   input  logic signed [31:0]        req_start_vel_y,
   input  logic signed [31:0]        req_start_vel_z,
   input  logic signed [31:0]        req_end_vel_x,
   input  logic signed [31:0]        req_end_vel_y,
   input  logic signed [31:0]        req_end_vel_z,
   output logic                      rsp_valid,
   output logic                      rsp_edge_valid,
   output logic signed [31:0]        rsp_q_invariant,
   output logic [31:0]               rsp_half_length,
   output logic                      rsp_saturated,
   input  logic                      csr_we,
   input  logic [evg_pkg::TOL_W-1:0] csr_wdata
);

   localparam int TOTAL = evg_pkg::TOTAL_LAT;
   localparam int OKLAT = evg_pkg::DIV_LAT + evg_pkg::PROD_LAT;
   localparam int PLAT  = evg_pkg::PROD_LAT;

   logic [evg_pkg::TOL_W-1:0] tol_ff;
   logic [TOTAL-1:0]          vld_ff;
   logic [OKLAT-1:0]          ok_ff;
   logic [31:0]               half_ff [0:PLAT-1];

   evg_pkg::front_type front;
   logic [8:0][31:0]   tensor;
   logic [8:0]         tsat;
   logic [31:0]        half_len;
   logic [31:0]        q_val;
   logic               q_sat;

   assign busy = 1'b0;

   always_ff @(posedge clock) begin
      if (reset)
         tol_ff <= evg_pkg::TOL_RESET;
      else if (csr_we)
         tol_ff <= csr_wdata;
   end

   always_ff @(posedge clock) begin
      if (reset)
         vld_ff <= '0;
      else
         vld_ff <= {vld_ff[TOTAL-2:0], start & ~busy};
   end

   evg_front u_front (
      .clock     (clock),
      .start_pos ({req_start_z, req_start_y, req_start_x}),
      .end_pos   ({req_end_z, req_end_y, req_end_x}),
      .start_vel ({req_start_vel_z, req_start_vel_y, req_start_vel_x}),
      .end_vel   ({req_end_vel_z, req_end_vel_y, req_end_vel_x}),
      .tolerance (tol_ff),
      .front     (front)
   );

   for (genvar i = 0; i < 3; i++) begin : g_row
      for (genvar j = 0; j < 3; j++) begin : g_col
         evg_div #(.FRAC_BITS(FRAC_BITS)) u_div (
            .clock   (clock),
            .num_mag (front.dv_mag[i]),
            .num_neg (front.dv_neg[i]),
            .den_mag (front.dx_mag[j]),
            .den_neg (front.dx_neg[j]),
            .quot    (tensor[i*3+j]),
            .sat     (tsat[i*3+j])
         );
      end
   end

   evg_sqrt u_sqrt (
      .clock    (clock),
      .dx_mag   (front.dx_mag),
      .half_len (half_len)
   );

   evg_qsum #(.FRAC_BITS(FRAC_BITS)) u_qsum (
      .clock   (clock),
      .tensor  (tensor),
      .sat_in  (|tsat),
      .q_val   (q_val),
      .sat_out (q_sat)
   );

   always_ff @(posedge clock) begin
      ok_ff      <= {ok_ff[OKLAT-2:0], front.ok};
      half_ff[0] <= half_len;
      for (int k = 1; k < PLAT; k++)
         half_ff[k] <= half_ff[k-1];
   end

   // a rejected edge reports zeros
   assign rsp_valid       = vld_ff[TOTAL-1];
   assign rsp_edge_valid  = ok_ff[OKLAT-1];
   assign rsp_q_invariant = ok_ff[OKLAT-1] ? $signed(q_val) : 32'sd0;
   assign rsp_half_length = ok_ff[OKLAT-1] ? half_ff[PLAT-1] : 32'd0;
   assign rsp_saturated   = ok_ff[OKLAT-1] & q_sat;

`include "edge_velocity_gradient_q_assert.svh"

   `EVG_ASSERT_AFTER(a_fixed_latency, start && !busy, evg_pkg::TOTAL_LAT, rsp_valid)
   `EVG_ASSERT_NOW(a_reject_zero, rsp_valid && !rsp_edge_valid,
      rsp_q_invariant == 32'sd0 && rsp_half_length == 32'd0 && !rsp_saturated)
   `EVG_ASSERT_NEXT(a_csr_write, csr_we, tol_ff == $past(csr_wdata))

endmodule
